FILE: rtl/core/sstp_pkg.sv
// Package: shared types and constants for the SMBIOS structure table parser.
package sstp_pkg;

   localparam logic [7:0] HEADER_BYTES      = 8'd4;
   localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;

   typedef enum logic [2:0] {
      PHASE_HEADER    = 3'b001,
      PHASE_FORMATTED = 3'b010,
      PHASE_STRINGS   = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      STAT_OK               = 3'd0,
      STAT_HEADER_PAST_END  = 3'd1,
      STAT_FORMATTED_PAST   = 3'd2,
      STAT_UNTERMINATED     = 3'd3,
      STAT_BAD_LENGTH       = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_TABLE_LENGTH    = 1'b0,
      CSR_STRUCTURE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] structure_index;
      logic [7:0]  structure_type;
      logic [7:0]  formatted_length;
      logic [15:0] string_offset;
      logic [15:0] string_count;
      logic        table_done;
      status_type  parse_status;
   } record_type;

endpackage

FILE: rtl/core/smbios_structure_table_parser.sv
// Top level: SMBIOS structure table parser with input and result registers.
//
//   channel  direction  handshake           beat
//   req      in         req_valid/ready     one table byte and restart flag
//   rsp      out        rsp_valid/ready     one structure record or error record
//   csr      in         csr_write_enable    table length / structure limit
//
// One byte per cycle unless a record stalls: an input register feeds the
// walker, whose state is registered; records land in an output register.
// A record turns valid in the output register when its byte advances.
// A byte that yields no record moves on even while a record waits; a byte
// that yields a record holds in the input register until the output frees.
// Synchronous reset clears all parse state, both valid flags and the CSRs.
module smbios_structure_table_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_table_byte,
   input  logic        req_table_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_structure_index,
   output logic [7:0]  rsp_structure_type,
   output logic [7:0]  rsp_formatted_length,
   output logic [15:0] rsp_string_offset,
   output logic [15:0] rsp_string_count,
   output logic        rsp_table_done,
   output logic [2:0]  rsp_parse_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_start_ff;
   logic                 out_valid_ff, out_valid_in;
   sstp_pkg::record_type out_rec_ff;
   logic [15:0]          tlen_ff;
   logic [15:0]          slim_ff;
   logic                 walk_emit;
   sstp_pkg::record_type walk_rec;
   logic                 advance;

   sstp_walker u_walker (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .table_byte      (in_byte_ff),
      .table_start     (in_start_ff),
      .table_length    (tlen_ff),
      .structure_limit (slim_ff),
      .emit            (walk_emit),
      .record          (walk_rec)
   );

   assign advance   = in_valid_ff && (!walk_emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && walk_emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tlen_ff      <= 16'd0;
         slim_ff      <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            unique case (sstp_pkg::csr_index_type'(csr_index))
               sstp_pkg::CSR_TABLE_LENGTH:    tlen_ff <= csr_data;
               sstp_pkg::CSR_STRUCTURE_LIMIT: slim_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_table_byte;
         in_start_ff <= req_table_start;
      end
      if (advance && walk_emit) begin
         out_rec_ff <= walk_rec;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_structure_index  = out_rec_ff.structure_index;
   assign rsp_structure_type   = out_rec_ff.structure_type;
   assign rsp_formatted_length = out_rec_ff.formatted_length;
   assign rsp_string_offset    = out_rec_ff.string_offset;
   assign rsp_string_count     = out_rec_ff.string_count;
   assign rsp_table_done       = out_rec_ff.table_done;
   assign rsp_parse_status     = out_rec_ff.parse_status;

`ifndef SYNTH
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))
      else $error("stalled input beat lost");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_done |-> rsp_parse_status == sstp_pkg::STAT_OK)
      else $error("done record carries an error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_parse_status <= sstp_pkg::STAT_BAD_LENGTH)
      else $error("status code out of range");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parse_status == sstp_pkg::STAT_UNTERMINATED ||
                    rsp_parse_status == sstp_pkg::STAT_FORMATTED_PAST ||
                    rsp_parse_status == sstp_pkg::STAT_BAD_LENGTH)
      |-> rsp_string_offset == 16'd0 && rsp_string_count == 16'd0 && !rsp_table_done)
      else $error("error record carries string fields");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_rec_ff))
      else $error("pending record overwritten");
`endif

endmodule

FILE: rtl/core/sstp_walker.sv
// Walker: parse state registers and per-beat structure decode.
module sstp_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          table_byte,
   input  logic                table_start,
   input  logic [15:0]         table_length,
   input  logic [15:0]         structure_limit,
   output logic                emit,
   output sstp_pkg::record_type record
);

   logic [15:0]         pos_ff, pos_in;
   logic [15:0]         ss_ff, ss_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          len_ff, len_in;
   logic [15:0]         seen_ff, seen_in;
   logic                prev_ff, prev_in;
   sstp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         done_ff, done_in;
   logic                halt_ff, halt_in;

   logic [15:0]         e_pos, e_ss, e_seen, e_done, off;
   logic [7:0]          e_type, e_len;
   logic                e_prev, e_halt;
   sstp_pkg::phase_type e_phase;
   logic [16:0]         sstart;
   logic [15:0]         cnt;

   always_comb begin
      e_pos   = table_start ? 16'd0 : pos_ff;
      e_ss    = table_start ? 16'd0 : ss_ff;
      e_type  = table_start ? 8'd0 : type_ff;
      e_len   = table_start ? 8'd0 : len_ff;
      e_seen  = table_start ? 16'd0 : seen_ff;
      e_prev  = table_start ? 1'b0 : prev_ff;
      e_phase = table_start ? sstp_pkg::PHASE_HEADER : phase_ff;
      e_done  = table_start ? 16'd0 : done_ff;
      e_halt  = table_start ? 1'b0 : halt_ff;
      off     = e_pos - e_ss;
      sstart  = {1'b0, e_ss} + {9'd0, e_len};
      cnt     = e_seen + {15'd0, ({2'b00, e_pos} > ({1'b0, sstart} + 18'd1))};

      pos_in   = e_pos;
      ss_in    = e_ss;
      type_in  = e_type;
      len_in   = e_len;
      seen_in  = e_seen;
      prev_in  = e_prev;
      phase_in = e_phase;
      done_in  = e_done;
      halt_in  = e_halt;
      emit     = 1'b0;
      record   = '{structure_index: e_done, structure_type: e_type,
                   formatted_length: e_len, string_offset: 16'd0, string_count: 16'd0,
                   table_done: 1'b0, parse_status: sstp_pkg::STAT_OK};

      if (!e_halt) begin
         pos_in = e_pos + 16'd1;
         unique case (e_phase)
            sstp_pkg::PHASE_FORMATTED: begin
               if (({1'b0, off} + 17'd1) >= {9'd0, e_len}) begin
                  phase_in = sstp_pkg::PHASE_STRINGS;
                  seen_in  = 16'd0;
                  prev_in  = 1'b0;
               end
            end
            sstp_pkg::PHASE_STRINGS: begin
               if (!(e_prev && table_byte == 8'd0)) begin
                  if (e_prev) begin
                     seen_in = e_seen + 16'd1;
                  end
                  prev_in = (table_byte == 8'd0);
                  if (({1'b0, e_pos} + 17'd1) >= {1'b0, table_length}) begin
                     halt_in = 1'b1;
                     emit    = 1'b1;
                     record.parse_status = sstp_pkg::STAT_UNTERMINATED;
                  end
               end else begin
                  emit    = 1'b1;
                  done_in = e_done + 16'd1;
                  halt_in = 1'b1;
                  record.string_offset = sstart[15:0];
                  record.string_count  = cnt;
                  if (e_type == sstp_pkg::END_OF_TABLE_TYPE ||
                      ({1'b0, e_done} + 17'd1) >= {1'b0, structure_limit}) begin
                     record.table_done = 1'b1;
                  end else if (({1'b0, e_pos} + 17'd5) > {1'b0, table_length}) begin
                     record.parse_status = sstp_pkg::STAT_HEADER_PAST_END;
                  end else begin
                     halt_in  = 1'b0;
                     ss_in    = e_pos + 16'd1;
                     type_in  = 8'd0;
                     len_in   = 8'd0;
                     phase_in = sstp_pkg::PHASE_HEADER;
                  end
               end
            end
            sstp_pkg::PHASE_HEADER: begin
               if (off == 16'd0) begin
                  record.structure_type   = 8'd0;
                  record.formatted_length = 8'd0;
                  len_in = 8'd0;
                  if (table_length == 16'd0 || structure_limit == 16'd0) begin
                     type_in = 8'd0;
                     halt_in = 1'b1;
                     emit    = 1'b1;
                     record.parse_status = sstp_pkg::STAT_BAD_LENGTH;
                  end else if (({1'b0, e_ss} + {9'd0, sstp_pkg::HEADER_BYTES}) >
                               {1'b0, table_length}) begin
                     type_in = 8'd0;
                     halt_in = 1'b1;
                     emit    = 1'b1;
                     record.parse_status = sstp_pkg::STAT_HEADER_PAST_END;
                  end else begin
                     type_in = table_byte;
                  end
               end else if (off == 16'd1) begin
                  len_in = table_byte;
                  record.formatted_length = table_byte;
                  if (table_byte < sstp_pkg::HEADER_BYTES) begin
                     halt_in = 1'b1;
                     emit    = 1'b1;
                     record.parse_status = sstp_pkg::STAT_BAD_LENGTH;
                  end else if (({2'b00, e_ss} + {10'd0, table_byte} + 18'd2) >
                               {2'b00, table_length}) begin
                     halt_in = 1'b1;
                     emit    = 1'b1;
                     record.parse_status = sstp_pkg::STAT_FORMATTED_PAST;
                  end
               end else if (off >= {8'd0, sstp_pkg::HEADER_BYTES - 8'd1}) begin
                  if (e_len <= sstp_pkg::HEADER_BYTES) begin
                     phase_in = sstp_pkg::PHASE_STRINGS;
                     seen_in  = 16'd0;
                     prev_in  = 1'b0;
                  end else begin
                     phase_in = sstp_pkg::PHASE_FORMATTED;
                  end
               end
            end
            default: begin
               halt_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 16'd0;
         ss_ff    <= 16'd0;
         type_ff  <= 8'd0;
         len_ff   <= 8'd0;
         seen_ff  <= 16'd0;
         prev_ff  <= 1'b0;
         phase_ff <= sstp_pkg::PHASE_HEADER;
         done_ff  <= 16'd0;
         halt_ff  <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         ss_ff    <= ss_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         halt_ff  <= halt_in;
      end
   end

endmodule
